// ===== hw/rtl/spt_pkg.sv =====
package spt_pkg;

   localparam int PositionWidth = 32;
   localparam int RateWidth     = 16;
   localparam int OpWidth       = 3;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 32;

   // Stream beat widths, rounded up to whole bytes.
   localparam int ReqDataWidth = 56;
   localparam int RspDataWidth = 56;

   typedef enum logic [OpWidth-1:0] {
      OP_STEP = 3'd0,
      OP_GOTO = 3'd1,
      OP_MOVE = 3'd2,
      OP_FREE = 3'd3,
      OP_STOP = 3'd4,
      OP_HOME = 3'd5
   } op_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MIN_POSITION = 2'd0,
      CSR_MIN_ENABLE   = 2'd1,
      CSR_MAX_POSITION = 2'd2,
      CSR_MAX_ENABLE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PositionWidth-1:0] min_position;
      logic                     min_enable;
      logic [PositionWidth-1:0] max_position;
      logic                     max_enable;
   } csr_type;

   typedef struct packed {
      logic [PositionWidth-1:0] position;
      logic [PositionWidth-1:0] target;
      logic                     forward;
      logic                     free_mode;
      logic [RateWidth-1:0]     rate;
   } state_type;

   // One command as it sits in the input register.
   typedef struct packed {
      logic [OpWidth-1:0]       operation;
      logic [PositionWidth-1:0] amount;
      logic                     forward;
      logic [RateWidth-1:0]     rate;
   } cmd_type;

endpackage

// ===== hw/rtl/stepper_position_tracker_core.sv =====
// Stepper motor position tracker.
//
// Commands and step-edge events arrive as beats on the req_ stream: the
// operation code travels in req_tuser, its operands in req_tdata. Every
// accepted beat yields exactly one rsp_ beat carrying the position, the
// direction pin level, the step rate to drive and the free-run flag as they
// stand after that event.
//
// The datapath is two registers deep: a beat is captured in the input
// register, the next state is computed from it combinationally and written
// both to the state registers and to the result register. rsp_tvalid rises
// when that write happens, and one beat is taken every cycle while the
// receiver keeps rsp_tready high. When the receiver holds rsp_tready low,
// the result register keeps its beat, the input register fills, and
// req_tready drops once both are full; no beat is lost or repeated. The
// update of the state is a single compare-and-add stage, which sets the
// one-beat-per-cycle figure.
//
// Soft limits are written through the csr_ port; the user must write them only while the stream is idle (not enforced).
// Reset clears both stream registers, the limits (disabled, zero) and the
// state: position zero, target zero, forward, not free running, stopped.
module stepper_position_tracker_core
   import spt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [31:0] amount, [32] forward, [48:33] rate, [55:49] zero
   input  logic [ReqDataWidth-1:0]  req_tdata,
   // [2:0] operation
   input  logic [OpWidth-1:0]       req_tuser,

   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [31:0] position, [32] direction_level, [48:33] step_rate,
   // [49] free_running, [55:50] zero
   output logic [RspDataWidth-1:0]  rsp_tdata,

   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   csr_type   cfg;
   state_type state_ff;
   state_type state_in;
   state_type state_next;
   cmd_type   cmd_ff;
   cmd_type   cmd_in;
   logic      cmd_valid_ff;
   logic      cmd_valid_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic [RspDataWidth-1:0] rsp_data_ff;
   logic [RspDataWidth-1:0] rsp_data_in;
   logic      advance;
   logic      req_take;

   spt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spt_update u_update (
      .cmd        (cmd_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_next)
   );

   // The held command moves on whenever the result register is free or
   // is being emptied in this cycle.
   assign advance    = cmd_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !cmd_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      cmd_in = cmd_ff;
      if (req_take) begin
         cmd_in.operation = req_tuser;
         cmd_in.amount    = req_tdata[31:0];
         cmd_in.forward   = req_tdata[32];
         cmd_in.rate      = req_tdata[48:33];
      end
      cmd_valid_in = req_take || (cmd_valid_ff && !advance);

      state_in     = advance ? state_next : state_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_data_in = {(RspDataWidth-50)'(0), state_next.free_mode, state_next.rate,
                        state_next.forward, state_next.position};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         state_ff.position <= '0;
         state_ff.target   <= '0;
         state_ff.forward  <= 1'b1;
         state_ff.free_mode <= 1'b0;
         state_ff.rate     <= '0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The tracked state changes only when a command is executed.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an executed command");

   // A stop command always leaves the motor stopped.
   a_stop_stops: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.operation == OP_STOP) |=> (state_ff.rate == '0))
      else $error("stop did not clear the step rate");

   // Set home puts the position at zero.
   a_home_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.operation == OP_HOME) |=> (state_ff.position == '0))
      else $error("set home did not zero the position");

   // Free rotate enters free-run mode and the result reports it.
   a_free_mode: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff.operation == OP_FREE) |=> (state_ff.free_mode && rsp_tdata[49]))
      else $error("free rotate did not set free-run mode");
`endif

endmodule

// ===== hw/rtl/spt_csr.sv =====
module spt_csr
   import spt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output csr_type                  cfg
);

   csr_type cfg_ff;
   csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_POSITION: cfg_in.min_position = csr_wdata[PositionWidth-1:0];
            CSR_MIN_ENABLE:   cfg_in.min_enable   = csr_wdata[0];
            CSR_MAX_POSITION: cfg_in.max_position = csr_wdata[PositionWidth-1:0];
            CSR_MAX_ENABLE:   cfg_in.max_enable   = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/spt_update.sv =====
module spt_update
   import spt_pkg::*;
(
   input  cmd_type   cmd,
   input  state_type state,
   input  csr_type   cfg,
   output state_type state_next
);

   logic [PositionWidth-1:0] step_pos;
   logic [PositionWidth-1:0] dest;
   logic                     hit_target;
   logic                     hit_min;
   logic                     hit_max;

   always_comb begin
      step_pos = state.forward ? state.position + PositionWidth'(1)
                               : state.position - PositionWidth'(1);
      hit_target = !state.free_mode && (state.target == step_pos);
      hit_min = cfg.min_enable && ($signed(step_pos) <= $signed(cfg.min_position));
      hit_max = cfg.max_enable && ($signed(step_pos) >= $signed(cfg.max_position));

      if (cmd.operation == OP_GOTO) begin
         dest = cmd.amount;
      end else if (cmd.forward) begin
         dest = state.position + cmd.amount;
      end else begin
         dest = state.position - cmd.amount;
      end

      state_next = state;
      case (op_type'(cmd.operation))
         OP_STEP: begin
            state_next.position = step_pos;
            if (hit_target || hit_min || hit_max) begin
               state_next.rate = '0;
            end
         end
         OP_GOTO, OP_MOVE: begin
            state_next.free_mode = 1'b0;
            // A move onto the current position leaves target, direction and rate alone.
            if (dest != state.position) begin
               state_next.target  = dest;
               state_next.forward = $signed(dest) > $signed(state.position);
               state_next.rate    = cmd.rate;
            end
         end
         OP_FREE: begin
            state_next.forward   = cmd.forward;
            state_next.rate      = cmd.rate;
            state_next.free_mode = 1'b1;
         end
         OP_STOP: state_next.rate = '0;
         OP_HOME: state_next.position = '0;
         default: state_next = state;
      endcase
   end

endmodule
